FILE: rtl/core/lfu_cache_with_lru_tiebreak_top_defines.svh
// ============================================================================
// LFU cache assertion macros
// Shared assertion shorthands for the cache checker. Each macro samples on
// i_clk and is disabled while i_rst_n is low.
// ============================================================================
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent does.
`define LFU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lfu_pkg.sv
// ============================================================================
// LFU cache package
// Types and constants shared by the LFU cache modules.
// ============================================================================
package lfu_pkg;

    // Default number of cache slots.
    localparam int ENTRIES_DEF = 16;

    // Field widths.
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 32;
    localparam int STAMP_W = 48;
    localparam int CAP_W   = 5;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // Register reset values and limits.
    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Register index (word address bit above the byte lanes).
    localparam logic REG_CAPACITY = 1'b0;

    // Command transaction payload.
    typedef struct packed {
        logic                     opcode;
        logic signed [KEY_W-1:0]  lookup_key;
        logic signed [VAL_W-1:0]  store_value;
    } t_lfu_in;

    // Result transaction payload.
    typedef struct packed {
        logic                     found;
        logic signed [VAL_W-1:0]  read_value;
    } t_lfu_out;

    // One stored cache entry.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int RANK_W  = COUNT_W + STAMP_W;

endpackage

FILE: rtl/core/lfu_cache_with_lru_tiebreak_top.sv
// ============================================================================
// LFU cache with LRU tie-break, top level
// APB capacity register, entry memory and the scanning sequencer.
// ============================================================================
// A command is taken when start is high while busy is low; busy then stays
// high until the command's single result has been prepared. Each command reads
// every occupied slot once through the one read port of the entry memory, and
// the result appears on o_result with o_done high for exactly one cycle right
// after busy falls. The result must be taken in that cycle; there is no way to
// hold it off. A new command may be started in that same cycle.
// No clearing pass runs after reset; the block accepts commands at once.
module lfu_cache_with_lru_tiebreak_top #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  lfu_pkg::t_lfu_in            i_cmd,
    output logic                        o_done,
    output lfu_pkg::t_lfu_out           o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfu_pkg::PADDR_W-1:0] paddr,
    input  logic [lfu_pkg::APB_W-1:0]   pwdata,
    output logic [lfu_pkg::APB_W-1:0]   prdata,
    output logic                        pready
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [lfu_pkg::CAP_W-1:0] r_cap;
    logic [lfu_pkg::CAP_W-1:0] cap_eff;
    logic                      cfg_wr;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    lfu_pkg::t_entry           ram_wdata;
    lfu_pkg::t_entry           ram_rdata;

    // Configuration write transaction.
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lfu_pkg::CAP_RESET;
        end else if (cfg_wr && (paddr[2] == lfu_pkg::REG_CAPACITY)) begin
            r_cap <= pwdata[lfu_pkg::CAP_W-1:0];
        end
    end

    // Read-back and ready.
    assign prdata = (paddr[2] == lfu_pkg::REG_CAPACITY) ?
                    {{(lfu_pkg::APB_W-lfu_pkg::CAP_W){1'b0}}, r_cap} : '0;
    assign pready = 1'b1;

    // The capacity never exceeds the number of physical slots.
    assign cap_eff = ({{(32-lfu_pkg::CAP_W){1'b0}}, r_cap} > 32'(ENTRIES)) ?
                     lfu_pkg::CAP_W'(ENTRIES) : r_cap;

    lfu_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_cap       (cap_eff),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    lfu_ram #(
        .WIDTH (lfu_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: rtl/core/lfu_ram.sv
// ============================================================================
// LFU generic RAM
// Single write port, single read port memory with registered read data.
// ============================================================================
module lfu_ram #(
    parameter int WIDTH = lfu_pkg::ENTRY_W,
    parameter int DEPTH = lfu_pkg::ENTRIES_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lfu_ctrl.sv
// ============================================================================
// LFU cache sequencer
// Scans the valid slots one per cycle through a single compare unit that
// finds the key match and the lowest-count, oldest victim, then writes back a hit or an inserted entry.
// ============================================================================
module lfu_ctrl #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    output logic                                          o_busy,
    input  lfu_pkg::t_lfu_in                              i_cmd,
    input  logic [lfu_pkg::CAP_W-1:0]                     i_cap,
    output logic                                          o_done,
    output lfu_pkg::t_lfu_out                             o_result,
    output logic                                          o_ram_re,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_ram_raddr,
    input  lfu_pkg::t_entry                               i_ram_rdata,
    output logic                                          o_ram_we,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_ram_waddr,
    output lfu_pkg::t_entry                               o_ram_wdata
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    lfu_pkg::t_lfu_in                r_cmd;
    logic [lfu_pkg::CAP_W-1:0]       r_occ, n_occ;
    logic [lfu_pkg::STAMP_W-1:0]     r_clock, n_clock;
    logic [lfu_pkg::CAP_W-1:0]       r_cnt;
    logic                            r_dv;
    logic [AW-1:0]                   r_dv_idx;
    logic                            r_hit;
    logic [AW-1:0]                   r_hit_idx;
    lfu_pkg::t_entry                 r_hit_rec;
    logic                            r_have_vic;
    logic [AW-1:0]                   r_vic_idx;
    logic [lfu_pkg::RANK_W-1:0]      r_vic_rank;
    logic                            r_done;
    lfu_pkg::t_lfu_out               r_result;

    logic                            accept;
    logic                            issue;
    logic                            key_match;
    logic [lfu_pkg::RANK_W-1:0]      cur_rank;
    logic                            better;
    logic                            is_put;
    logic                            do_fill;
    logic                            do_evict;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    lfu_pkg::t_entry                 wr_rec;
    logic [lfu_pkg::COUNT_W-1:0]     inc_count;

    assign accept = (r_state == ST_IDLE) && i_start;
    assign issue  = (r_state == ST_SCAN) && (r_cnt < r_occ);

    // Shared compare unit: key match and victim ranking on the slot just read.
    assign key_match = r_dv && (i_ram_rdata.key == r_cmd.lookup_key);
    assign cur_rank  = {i_ram_rdata.count, i_ram_rdata.stamp};
    assign better    = r_dv && (!r_have_vic || (cur_rank < r_vic_rank));

    // Write-back decision once the scan is complete.
    always_comb begin
        is_put    = (r_cmd.opcode == lfu_pkg::OP_PUT);
        do_fill   = is_put && !r_hit && (i_cap != '0) && (r_occ < i_cap);
        do_evict  = is_put && !r_hit && (i_cap != '0) && !(r_occ < i_cap);
        inc_count = (r_hit_rec.count == lfu_pkg::COUNT_MAX) ?
                    lfu_pkg::COUNT_MAX : r_hit_rec.count + 1'b1;
        wr_en     = (r_state == ST_WRITE) && (r_hit || do_fill || do_evict);
        wr_addr   = r_vic_idx;
        wr_rec    = r_hit_rec;
        if (r_hit) begin
            wr_addr       = r_hit_idx;
            wr_rec.count  = inc_count;
            wr_rec.stamp  = r_clock;
            if (is_put) begin
                wr_rec.value = r_cmd.store_value;
            end
        end else begin
            if (do_fill) begin
                wr_addr = AW'(r_occ);
            end
            wr_rec.key   = r_cmd.lookup_key;
            wr_rec.value = r_cmd.store_value;
            wr_rec.count = {{(lfu_pkg::COUNT_W-1){1'b0}}, 1'b1};
            wr_rec.stamp = r_clock;
        end
        n_occ   = do_fill && wr_en ? r_occ + 1'b1 : r_occ;
        n_clock = wr_en ? r_clock + 1'b1 : r_clock;
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_occ      <= '0;
            r_clock    <= '0;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            r_hit      <= 1'b0;
            r_have_vic <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_clock <= n_clock;
            r_dv    <= issue;
            r_done  <= (r_state == ST_WRITE);
            if (accept) begin
                r_cnt      <= '0;
                r_hit      <= 1'b0;
                r_have_vic <= 1'b0;
            end else begin
                if (issue) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (key_match) begin
                    r_hit <= 1'b1;
                end
                if (better) begin
                    r_have_vic <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_dv_idx <= AW'(r_cnt);
        if (key_match && !r_hit) begin
            r_hit_idx <= r_dv_idx;
            r_hit_rec <= i_ram_rdata;
        end
        if (better) begin
            r_vic_idx  <= r_dv_idx;
            r_vic_rank <= cur_rank;
        end
        if (r_state == ST_WRITE) begin
            r_result.found      <= r_hit;
            r_result.read_value <= (r_hit && !is_put) ? r_hit_rec.value : '0;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_ram_re    = issue;
    assign o_ram_raddr = AW'(r_cnt);
    assign o_ram_we    = wr_en;
    assign o_ram_waddr = wr_addr;
    assign o_ram_wdata = wr_rec;

endmodule

FILE: rtl/core/lfu_chk.sv
// ============================================================================
// LFU cache port checker
// Watches the top-level ports for command and result sequencing errors.
// ============================================================================
`include "lfu_cache_with_lru_tiebreak_top_defines.svh"

module lfu_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        o_done,
    input  lfu_pkg::t_lfu_out           o_result
);

    // An accepted command keeps the block busy in the following cycle.
    `LFU_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy did not rise after start")

    // A result is only presented once the block has finished its command.
    `LFU_ASSERT_SAME(a_done_not_busy, o_done, !busy, "result strobe while busy")

    // Each command yields a single result strobe.
    `LFU_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")

    // A miss never returns data.
    `LFU_ASSERT_SAME(a_miss_zero, o_done && !o_result.found, o_result.read_value == '0,
                     "nonzero read value on a miss")

endmodule

bind lfu_cache_with_lru_tiebreak_top lfu_chk u_lfu_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
